// ----- hw/rtl/pkc_pkg.sv -----
package pkc_pkg;

	// one accepted input item: a frame byte with its end marker
	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} pkc_item_t;

	// one result item
	typedef struct packed {
		logic [3:0]  frame_class;
		logic [2:0]  application_class;
		logic [31:0] arp_count;
		logic [31:0] ipv4_count;
		logic [31:0] ipv6_count;
		logic [31:0] tcp_count;
		logic [31:0] udp_count;
		logic [31:0] http_count;
		logic [31:0] smtp_count;
		logic [31:0] dns_count;
		logic [31:0] ftp_count;
		logic [31:0] frame_count;
	} pkc_result_t;

	// classified frame handed from front to back through the queue
	typedef struct packed {
		logic [3:0] frame_class;
		logic [2:0] application_class;
	} pkc_rec_t;

	// frame classes
	localparam logic [3:0] CLASS_OTHER      = 4'd0;
	localparam logic [3:0] CLASS_ARP        = 4'd1;
	localparam logic [3:0] CLASS_IPV4_OTHER = 4'd2;
	localparam logic [3:0] CLASS_IPV4_ICMP  = 4'd3;
	localparam logic [3:0] CLASS_IPV4_TCP   = 4'd4;
	localparam logic [3:0] CLASS_IPV4_UDP   = 4'd5;
	localparam logic [3:0] CLASS_IPV6_OTHER = 4'd6;
	localparam logic [3:0] CLASS_IPV6_TCP   = 4'd7;
	localparam logic [3:0] CLASS_IPV6_UDP   = 4'd8;

	// application classes
	localparam logic [2:0] APP_NONE = 3'd0;
	localparam logic [2:0] APP_HTTP = 3'd1;
	localparam logic [2:0] APP_SMTP = 3'd2;
	localparam logic [2:0] APP_DNS  = 3'd3;
	localparam logic [2:0] APP_FTP  = 3'd4;

	// protocol constants
	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [15:0] ETYPE_ARP  = 16'h0806;
	localparam logic [15:0] ETYPE_IPV6 = 16'h86dd;
	localparam logic [7:0]  PROTO_ICMP = 8'd1;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;
	localparam logic [15:0] PORT_HTTP  = 16'd80;
	localparam logic [15:0] PORT_SMTP  = 16'd25;
	localparam logic [15:0] PORT_DNS   = 16'd53;
	localparam logic [15:0] PORT_FTPD  = 16'd20;
	localparam logic [15:0] PORT_FTPC  = 16'd21;

	// counter slots
	localparam int CNT_ARP   = 0;
	localparam int CNT_IPV4  = 1;
	localparam int CNT_IPV6  = 2;
	localparam int CNT_TCP   = 3;
	localparam int CNT_UDP   = 4;
	localparam int CNT_HTTP  = 5;
	localparam int CNT_SMTP  = 6;
	localparam int CNT_DNS   = 7;
	localparam int CNT_FTP   = 8;
	localparam int CNT_FRAME = 9;
	localparam int NUM_CNT   = 10;

	// front-to-back queue
	localparam int QDEPTH = 2;

endpackage

// ----- hw/rtl/pkc_front.sv -----
module pkc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  pkc_pkg::pkc_item_t  item,
	output logic                push,
	output pkc_pkg::pkc_rec_t   rec,
	input  logic                q_full
);
	import pkc_pkg::*;

	logic [5:0]  off_q;
	logic [3:0]  seen_q;      // ethertype, protocol, source port, destination port
	logic [15:0] etype_q;
	logic [7:0]  proto_q;
	logic [15:0] sport_q;
	logic [15:0] dport_q;

	logic [3:0]  seen_n;
	logic [15:0] etype_n;
	logic [7:0]  proto_n;
	logic [15:0] sport_n;
	logic [15:0] dport_n;
	logic        v4;
	logic        v6;
	logic        acc;
	logic        transport;
	logic        m_http;
	logic        m_smtp;
	logic        m_dns;
	logic        m_ftp;

	assign item_ready = !q_full;
	assign acc        = item_valid && item_ready;
	assign push       = acc && item.last_byte;

	// capture state as it stands after this byte
	always_comb begin
		seen_n  = seen_q;
		etype_n = etype_q;
		proto_n = proto_q;
		sport_n = sport_q;
		dport_n = dport_q;
		if (off_q == 6'd12) begin
			etype_n[15:8] = item.frame_byte;
		end
		if (off_q == 6'd13) begin
			etype_n[7:0] = item.frame_byte;
			seen_n[0]    = 1'b1;
		end
		v4 = seen_n[0] && (etype_n == ETYPE_IPV4);
		v6 = seen_n[0] && (etype_n == ETYPE_IPV6);
		if ((v4 && off_q == 6'd23) || (v6 && off_q == 6'd20)) begin
			proto_n   = item.frame_byte;
			seen_n[1] = 1'b1;
		end
		if ((v4 && off_q == 6'd34) || (v6 && off_q == 6'd54)) begin
			sport_n[15:8] = item.frame_byte;
		end
		if ((v4 && off_q == 6'd35) || (v6 && off_q == 6'd55)) begin
			sport_n[7:0] = item.frame_byte;
			seen_n[2]    = 1'b1;
		end
		if ((v4 && off_q == 6'd36) || (v6 && off_q == 6'd56)) begin
			dport_n[15:8] = item.frame_byte;
		end
		if ((v4 && off_q == 6'd37) || (v6 && off_q == 6'd57)) begin
			dport_n[7:0] = item.frame_byte;
			seen_n[3]    = 1'b1;
		end
	end

	// a port only matches once both of its bytes arrived
	assign m_http = (seen_n[2] && sport_n == PORT_HTTP) || (seen_n[3] && dport_n == PORT_HTTP);
	assign m_smtp = (seen_n[2] && sport_n == PORT_SMTP) || (seen_n[3] && dport_n == PORT_SMTP);
	assign m_dns  = (seen_n[2] && sport_n == PORT_DNS)  || (seen_n[3] && dport_n == PORT_DNS);
	assign m_ftp  = (seen_n[2] && (sport_n == PORT_FTPD || sport_n == PORT_FTPC)) ||
	                (seen_n[3] && (dport_n == PORT_FTPD || dport_n == PORT_FTPC));

	// classification, only consumed on the last byte
	always_comb begin
		rec.frame_class       = CLASS_OTHER;
		rec.application_class = APP_NONE;
		transport             = 1'b0;
		if (seen_n[0]) begin
			if (etype_n == ETYPE_ARP) begin
				rec.frame_class = CLASS_ARP;
			end else if (etype_n == ETYPE_IPV4) begin
				rec.frame_class = CLASS_IPV4_OTHER;
				if (seen_n[1] && proto_n == PROTO_ICMP) begin
					rec.frame_class = CLASS_IPV4_ICMP;
				end else if (seen_n[1] && proto_n == PROTO_TCP) begin
					rec.frame_class = CLASS_IPV4_TCP;
					transport       = 1'b1;
				end else if (seen_n[1] && proto_n == PROTO_UDP) begin
					rec.frame_class = CLASS_IPV4_UDP;
					transport       = 1'b1;
				end
			end else if (etype_n == ETYPE_IPV6) begin
				rec.frame_class = CLASS_IPV6_OTHER;
				if (seen_n[1] && proto_n == PROTO_TCP) begin
					rec.frame_class = CLASS_IPV6_TCP;
					transport       = 1'b1;
				end else if (seen_n[1] && proto_n == PROTO_UDP) begin
					rec.frame_class = CLASS_IPV6_UDP;
					transport       = 1'b1;
				end
			end
		end
		if (transport) begin
			if (m_http) begin
				rec.application_class = APP_HTTP;
			end else if (m_smtp) begin
				rec.application_class = APP_SMTP;
			end else if (m_dns) begin
				rec.application_class = APP_DNS;
			end else if (m_ftp) begin
				rec.application_class = APP_FTP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q  <= '0;
			seen_q <= '0;
		end else if (acc) begin
			if (item.last_byte) begin
				off_q  <= '0;
				seen_q <= '0;
			end else begin
				if (off_q != 6'd63) begin
					off_q <= off_q + 6'd1;
				end
				seen_q <= seen_n;
			end
		end
	end

	// captured fields are qualified by seen_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			etype_q <= '0;
			proto_q <= '0;
			sport_q <= '0;
			dport_q <= '0;
		end else if (acc) begin
			etype_q <= etype_n;
			proto_q <= proto_n;
			sport_q <= sport_n;
			dport_q <= dport_n;
		end
	end

endmodule

// ----- hw/rtl/pkc_queue.sv -----
module pkc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pkc_pkg::pkc_rec_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output pkc_pkg::pkc_rec_t pop_data
);
	import pkc_pkg::*;

	localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	pkc_rec_t        mem_q [QDEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;

	assign full     = (cnt_q == CW'(QDEPTH));
	assign valid    = (cnt_q != '0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(QDEPTH - 1)) ? '0 : wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(QDEPTH - 1)) ? '0 : rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/pkc_back.sv -----
module pkc_back #(
	parameter int COUNTER_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_pop,
	input  pkc_pkg::pkc_rec_t    q_data,
	output logic                 result_valid,
	input  logic                 result_ready,
	output pkc_pkg::pkc_result_t result
);
	import pkc_pkg::*;

	localparam int MIN_W = (COUNTER_WIDTH < 32) ? COUNTER_WIDTH : 32;

	logic [COUNTER_WIDTH-1:0] cnt_q [NUM_CNT];
	logic [COUNTER_WIDTH-1:0] cnt_n [NUM_CNT];
	logic [NUM_CNT-1:0]       inc;
	logic                     valid_q;
	pkc_result_t              result_q;
	pkc_result_t              result_d;

	function automatic logic [31:0] to32(input logic [COUNTER_WIDTH-1:0] v);
		return 32'(v[MIN_W-1:0]);
	endfunction

	assign q_pop        = q_valid && (!valid_q || result_ready);
	assign result_valid = valid_q;
	assign result       = result_q;

	// counter increments from the frame record
	always_comb begin
		inc            = '0;
		inc[CNT_FRAME] = 1'b1;
		unique case (q_data.frame_class) inside
			CLASS_ARP: begin
				inc[CNT_ARP] = 1'b1;
			end
			CLASS_IPV4_OTHER, CLASS_IPV4_ICMP: begin
				inc[CNT_IPV4] = 1'b1;
			end
			CLASS_IPV4_TCP: begin
				inc[CNT_IPV4] = 1'b1;
				inc[CNT_TCP]  = 1'b1;
			end
			CLASS_IPV4_UDP: begin
				inc[CNT_IPV4] = 1'b1;
				inc[CNT_UDP]  = 1'b1;
			end
			CLASS_IPV6_OTHER: begin
				inc[CNT_IPV6] = 1'b1;
			end
			CLASS_IPV6_TCP: begin
				inc[CNT_IPV6] = 1'b1;
				inc[CNT_TCP]  = 1'b1;
			end
			CLASS_IPV6_UDP: begin
				inc[CNT_IPV6] = 1'b1;
				inc[CNT_UDP]  = 1'b1;
			end
			default: begin
			end
		endcase
		unique case (q_data.application_class)
			APP_HTTP: inc[CNT_HTTP] = 1'b1;
			APP_SMTP: inc[CNT_SMTP] = 1'b1;
			APP_DNS:  inc[CNT_DNS]  = 1'b1;
			APP_FTP:  inc[CNT_FTP]  = 1'b1;
			default: begin
			end
		endcase
	end

	always_comb begin
		for (int i = 0; i < NUM_CNT; i++) begin
			cnt_n[i] = cnt_q[i] + COUNTER_WIDTH'(inc[i]);
		end
	end

	always_comb begin
		result_d.frame_class       = q_data.frame_class;
		result_d.application_class = q_data.application_class;
		result_d.arp_count         = to32(cnt_n[CNT_ARP]);
		result_d.ipv4_count        = to32(cnt_n[CNT_IPV4]);
		result_d.ipv6_count        = to32(cnt_n[CNT_IPV6]);
		result_d.tcp_count         = to32(cnt_n[CNT_TCP]);
		result_d.udp_count         = to32(cnt_n[CNT_UDP]);
		result_d.http_count        = to32(cnt_n[CNT_HTTP]);
		result_d.smtp_count        = to32(cnt_n[CNT_SMTP]);
		result_d.dns_count         = to32(cnt_n[CNT_DNS]);
		result_d.ftp_count         = to32(cnt_n[CNT_FTP]);
		result_d.frame_count       = to32(cnt_n[CNT_FRAME]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			for (int i = 0; i < NUM_CNT; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (q_pop) begin
				valid_q <= 1'b1;
				for (int i = 0; i < NUM_CNT; i++) begin
					cnt_q[i] <= cnt_n[i];
				end
			end else if (result_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			result_q <= result_d;
		end
	end

endmodule

// ----- hw/rtl/packet_type_classifier_counters_unit.sv -----
// Channel   Handshake                   Payload                Moves
// item      item_valid / item_ready     item (pkc_item_t)      one frame byte
// result    result_valid / result_ready result (pkc_result_t)  one classified frame
//
// One item is taken every cycle; item_ready drops only while the two-entry
// queue between front and back is full, i.e. when result_ready has been low.
// A result becomes valid once the item carrying last_byte is taken: the
// accepting edge writes the record into the queue, and once the output
// register is free the record moves through the counter update into the
// output register. Reset (arst_n, async) zeroes all counters and the
// per-frame capture state at once; no clearing pass is needed.
module packet_type_classifier_counters_unit #(
	parameter int COUNTER_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  pkc_pkg::pkc_item_t   item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output pkc_pkg::pkc_result_t result
);
	import pkc_pkg::*;

	// front -> queue
	logic     push;
	pkc_rec_t push_rec;
	logic     q_full;

	// queue -> back
	logic     q_valid;
	logic     q_pop;
	pkc_rec_t q_rec;

	// front: byte offset tracking, field capture, frame classification
	pkc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push       (push),
		.rec        (push_rec),
		.q_full     (q_full)
	);

	// decouples the byte stream from result backpressure
	pkc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_rec),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_rec)
	);

	// back: counter update and registered result
	pkc_back #(
		.COUNTER_WIDTH (COUNTER_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.q_data       (q_rec),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// the front never writes a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("queue written while full");

	// the back only pops a record that exists
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	// an application is reported only for tcp or udp frames
	a_app_needs_transport: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.application_class != APP_NONE) |->
		(result.frame_class == CLASS_IPV4_TCP || result.frame_class == CLASS_IPV4_UDP ||
		 result.frame_class == CLASS_IPV6_TCP || result.frame_class == CLASS_IPV6_UDP))
		else $error("application class without tcp or udp");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import pkc_pkg::*;

	// capture flags, one bit per header field taken from the frame
	localparam int SEEN_ETYPE = 0;
	localparam int SEEN_PROTO = 1;
	localparam int SEEN_SPORT = 2;
	localparam int SEEN_DPORT = 3;

	localparam int RAND_BYTES  = 250;
	localparam int RAND_FRAMES = 6;
	localparam int DRAIN_WAIT  = 20;

	// one frame of the directed table; cls/app are only meaningful when typed is set
	typedef struct packed {
		logic [7:0]  len;
		logic [15:0] et;
		logic [7:0]  pr;
		logic [15:0] sp;
		logic [15:0] dp;
		logic        typed;
		logic [3:0]  cls;
		logic [2:0]  app;
	} frame_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	pkc_item_t   item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	pkc_result_t result;

	packet_type_classifier_counters_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hang guard: far beyond the slowest legal run
	initial begin
		#50_000_000;
		$display("[packet_type_classifier_counters_unit] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor state: per-frame capture plus the ten running counters.
	// ------------------------------------------------------------------
	logic [5:0]  off_q;
	logic [15:0] etype_q;
	logic [7:0]  proto_q;
	logic [15:0] sport_q;
	logic [15:0] dport_q;
	logic [3:0]  seen_q;
	logic [31:0] cnt_q [NUM_CNT];

	pkc_result_t expected_frames [$];

	int err_cnt = 0;
	int checked = 0;
	int frame_cnt = 0;
	int byte_cnt = 0;

	function automatic bit port_hit(input logic [15:0] p);
		return (seen_q[SEEN_SPORT] && sport_q == p) || (seen_q[SEEN_DPORT] && dport_q == p);
	endfunction

	function automatic void clear_capture();
		off_q = '0;
		etype_q = '0;
		proto_q = '0;
		sport_q = '0;
		dport_q = '0;
		seen_q = '0;
	endfunction

	// Advance the capture by one byte; on the frame's last byte, classify,
	// bump the counters and hand back the result the block should emit.
	task automatic classify_byte(input logic [7:0] b, input logic last,
			output bit emitted, output pkc_result_t r);
		logic v4, v6, xport;
		int base;
		logic [3:0] cls;
		logic [2:0] app;
		emitted = 1'b0;
		r = '0;
		cls = CLASS_OTHER;
		app = APP_NONE;
		xport = 1'b0;

		if (off_q == 6'd12) etype_q[15:8] = b;
		if (off_q == 6'd13) begin
			etype_q[7:0] = b;
			seen_q[SEEN_ETYPE] = 1'b1;
		end
		v4 = seen_q[SEEN_ETYPE] && etype_q == ETYPE_IPV4;
		v6 = seen_q[SEEN_ETYPE] && etype_q == ETYPE_IPV6;
		if (v4 || v6) begin
			// IPv4 protocol sits at 23, IPv6 next header at 20
			if ((v4 && off_q == 6'd23) || (v6 && off_q == 6'd20)) begin
				proto_q = b;
				seen_q[SEEN_PROTO] = 1'b1;
			end
			base = v4 ? 34 : 54;
			if (off_q == base) sport_q[15:8] = b;
			if (off_q == base + 1) begin
				sport_q[7:0] = b;
				seen_q[SEEN_SPORT] = 1'b1;
			end
			if (off_q == base + 2) dport_q[15:8] = b;
			if (off_q == base + 3) begin
				dport_q[7:0] = b;
				seen_q[SEEN_DPORT] = 1'b1;
			end
		end
		if (off_q != 6'd63) off_q = off_q + 6'd1;
		if (!last) return;

		emitted = 1'b1;
		cnt_q[CNT_FRAME]++;
		if (seen_q[SEEN_ETYPE]) begin
			if (etype_q == ETYPE_ARP) begin
				cls = CLASS_ARP;
				cnt_q[CNT_ARP]++;
			end else if (etype_q == ETYPE_IPV4) begin
				cnt_q[CNT_IPV4]++;
				cls = CLASS_IPV4_OTHER;
				if (seen_q[SEEN_PROTO] && proto_q == PROTO_ICMP) cls = CLASS_IPV4_ICMP;
				else if (seen_q[SEEN_PROTO] && proto_q == PROTO_TCP) begin
					cls = CLASS_IPV4_TCP;
					cnt_q[CNT_TCP]++;
					xport = 1'b1;
				end else if (seen_q[SEEN_PROTO] && proto_q == PROTO_UDP) begin
					cls = CLASS_IPV4_UDP;
					cnt_q[CNT_UDP]++;
					xport = 1'b1;
				end
			end else if (etype_q == ETYPE_IPV6) begin
				// no ICMPv6 class: anything but TCP/UDP is "ipv6 other"
				cnt_q[CNT_IPV6]++;
				cls = CLASS_IPV6_OTHER;
				if (seen_q[SEEN_PROTO] && proto_q == PROTO_TCP) begin
					cls = CLASS_IPV6_TCP;
					cnt_q[CNT_TCP]++;
					xport = 1'b1;
				end else if (seen_q[SEEN_PROTO] && proto_q == PROTO_UDP) begin
					cls = CLASS_IPV6_UDP;
					cnt_q[CNT_UDP]++;
					xport = 1'b1;
				end
			end
		end
		// application match priority: HTTP, SMTP, DNS, FTP
		if (xport) begin
			if (port_hit(PORT_HTTP)) begin
				app = APP_HTTP;
				cnt_q[CNT_HTTP]++;
			end else if (port_hit(PORT_SMTP)) begin
				app = APP_SMTP;
				cnt_q[CNT_SMTP]++;
			end else if (port_hit(PORT_DNS)) begin
				app = APP_DNS;
				cnt_q[CNT_DNS]++;
			end else if (port_hit(PORT_FTPD) || port_hit(PORT_FTPC)) begin
				app = APP_FTP;
				cnt_q[CNT_FTP]++;
			end
		end

		r.frame_class       = cls;
		r.application_class = app;
		r.arp_count         = cnt_q[CNT_ARP];
		r.ipv4_count        = cnt_q[CNT_IPV4];
		r.ipv6_count        = cnt_q[CNT_IPV6];
		r.tcp_count         = cnt_q[CNT_TCP];
		r.udp_count         = cnt_q[CNT_UDP];
		r.http_count        = cnt_q[CNT_HTTP];
		r.smtp_count        = cnt_q[CNT_SMTP];
		r.dns_count         = cnt_q[CNT_DNS];
		r.ftp_count         = cnt_q[CNT_FTP];
		r.frame_count       = cnt_q[CNT_FRAME];
		clear_capture();
	endtask

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [15:0] pick_port();
		if ($urandom_range(0, 1) == 0) return 16'($urandom);
		case ($urandom_range(0, 4))
			0: return PORT_HTTP;
			1: return PORT_SMTP;
			2: return PORT_DNS;
			3: return PORT_FTPD;
			default: return PORT_FTPC;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Item driver. Builds the frame around random filler, streams it byte
	// by byte, and predicts at each accepting edge. Typed rows replace the
	// predicted class/application with the hand-written values.
	// ------------------------------------------------------------------
	task automatic send_frame(input int len, input logic [15:0] et, input logic [7:0] pr,
			input logic [15:0] sp, input logic [15:0] dp,
			input bit typed, input logic [3:0] tcls, input logic [2:0] tapp);
		logic [7:0] fb [0:127];
		int hb;
		bit gappy;
		bit emitted;
		logic last;
		pkc_result_t want;
		for (int i = 0; i < 128; i++) fb[i] = 8'($urandom);
		fb[12] = et[15:8];
		fb[13] = et[7:0];
		if (et == ETYPE_IPV6) begin
			fb[20] = pr;
			hb = 54;
		end else begin
			fb[23] = pr;
			hb = 34;
		end
		fb[hb]     = sp[15:8];
		fb[hb + 1] = sp[7:0];
		fb[hb + 2] = dp[15:8];
		fb[hb + 3] = dp[7:0];
		// about a third of the frames go back to back
		gappy = $urandom_range(0, 2) != 0;

		for (int i = 0; i < len; i++) begin
			last = (i == len - 1);
			if (gappy && $urandom_range(0, 3) == 0) begin
				item_valid <= 1'b0;
				repeat (idle_len()) @(posedge clk);
			end
			item_valid <= 1'b1;
			item <= '{frame_byte: fb[i], last_byte: last};
			do @(posedge clk); while (!item_ready);
			classify_byte(fb[i], last, emitted, want);
			byte_cnt++;
			if (emitted) begin
				if (typed) begin
					want.frame_class = tcls;
					want.application_class = tapp;
				end
				expected_frames.push_back(want);
			end
		end
		frame_cnt++;
	endtask

	// sender holds off until the result side has caught up
	task automatic drain_pause();
		item_valid <= 1'b0;
		@(posedge clk);
		while (expected_frames.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result side: ready toggles between bursts and stalls of random length.
	// ------------------------------------------------------------------
	int rdy_hold = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			rdy_hold <= 0;
		end else if (rdy_hold != 0) begin
			rdy_hold <= rdy_hold - 1;
		end else if (result_ready) begin
			result_ready <= 1'b0;
			rdy_hold <= idle_len() - 1;
		end else begin
			result_ready <= 1'b1;
			// occasional long stretch without stalls
			rdy_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
			                                         : $urandom_range(0, 40);
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endfunction

	pkc_result_t head;

	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && result_ready) begin
			if (expected_frames.size() == 0) begin
				$error("result item with no frame outstanding");
				err_cnt++;
			end else begin
				head = expected_frames.pop_front();
				check_field("frame_class", 32'(head.frame_class), 32'(result.frame_class));
				check_field("application_class", 32'(head.application_class),
				            32'(result.application_class));
				check_field("arp_count", head.arp_count, result.arp_count);
				check_field("ipv4_count", head.ipv4_count, result.ipv4_count);
				check_field("ipv6_count", head.ipv6_count, result.ipv6_count);
				check_field("tcp_count", head.tcp_count, result.tcp_count);
				check_field("udp_count", head.udp_count, result.udp_count);
				check_field("http_count", head.http_count, result.http_count);
				check_field("smtp_count", head.smtp_count, result.smtp_count);
				check_field("dns_count", head.dns_count, result.dns_count);
				check_field("ftp_count", head.ftp_count, result.ftp_count);
				check_field("frame_count", head.frame_count, result.frame_count);
				checked++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Directed frames: short frames cut before each field, every class,
	// application priority, ports split across the frame end, extremes.
	// ------------------------------------------------------------------
	frame_row_t dir_rows [0:20] = '{
		// one-byte frame straight after reset
		'{8'd1,   16'h0000,   8'd0,       16'd0,     16'd0,     1'b1, CLASS_OTHER,      APP_NONE},
		// ethertype only half received
		'{8'd13,  ETYPE_IPV4, 8'd0,       16'd0,     16'd0,     1'b1, CLASS_OTHER,      APP_NONE},
		'{8'd14,  ETYPE_ARP,  8'd0,       16'd0,     16'd0,     1'b1, CLASS_ARP,        APP_NONE},
		// IPv4 cut before the protocol byte
		'{8'd14,  ETYPE_IPV4, PROTO_TCP,  16'd0,     16'd0,     1'b1, CLASS_IPV4_OTHER, APP_NONE},
		// ports ignored on ICMP
		'{8'd60,  ETYPE_IPV4, PROTO_ICMP, PORT_HTTP, PORT_DNS,  1'b1, CLASS_IPV4_ICMP,  APP_NONE},
		'{8'd60,  ETYPE_IPV4, PROTO_TCP,  PORT_HTTP, PORT_SMTP, 1'b1, CLASS_IPV4_TCP,   APP_HTTP},
		'{8'd38,  ETYPE_IPV4, PROTO_UDP,  16'd1000,  PORT_DNS,  1'b1, CLASS_IPV4_UDP,   APP_DNS},
		'{8'd64,  ETYPE_IPV4, PROTO_TCP,  PORT_SMTP, PORT_FTPC, 1'b1, CLASS_IPV4_TCP,   APP_SMTP},
		'{8'd60,  ETYPE_IPV4, PROTO_UDP,  PORT_FTPD, 16'd5000,  1'b1, CLASS_IPV4_UDP,   APP_FTP},
		// source port one byte short: no application
		'{8'd35,  ETYPE_IPV4, PROTO_TCP,  PORT_HTTP, PORT_HTTP, 1'b1, CLASS_IPV4_TCP,   APP_NONE},
		// source port complete, destination missing
		'{8'd36,  ETYPE_IPV4, PROTO_TCP,  PORT_DNS,  PORT_HTTP, 1'b1, CLASS_IPV4_TCP,   APP_DNS},
		// IPv6 cut before the next-header byte
		'{8'd20,  ETYPE_IPV6, PROTO_TCP,  16'd0,     16'd0,     1'b1, CLASS_IPV6_OTHER, APP_NONE},
		'{8'd80,  ETYPE_IPV6, PROTO_TCP,  16'd443,   PORT_HTTP, 1'b1, CLASS_IPV6_TCP,   APP_HTTP},
		'{8'd58,  ETYPE_IPV6, PROTO_UDP,  PORT_FTPC, PORT_DNS,  1'b1, CLASS_IPV6_UDP,   APP_DNS},
		// ICMPv6 next header is just "ipv6 other"
		'{8'd70,  ETYPE_IPV6, 8'd58,      PORT_HTTP, PORT_HTTP, 1'b1, CLASS_IPV6_OTHER, APP_NONE},
		'{8'd60,  ETYPE_IPV6, PROTO_ICMP, 16'd0,     16'd0,     1'b1, CLASS_IPV6_OTHER, APP_NONE},
		// long frame, offset saturates; all-ones ports
		'{8'd100, ETYPE_IPV4, PROTO_TCP,  16'hffff,  16'hffff,  1'b1, CLASS_IPV4_TCP,   APP_NONE},
		'{8'd60,  16'hffff,   8'hff,      16'hffff,  16'hffff,  1'b1, CLASS_OTHER,      APP_NONE},
		'{8'd40,  ETYPE_IPV4, 8'hff,      PORT_HTTP, PORT_HTTP, 1'b1, CLASS_IPV4_OTHER, APP_NONE},
		// IPv6 destination port one byte short
		'{8'd57,  ETYPE_IPV6, PROTO_UDP,  PORT_SMTP, PORT_HTTP, 1'b1, CLASS_IPV6_UDP,   APP_SMTP},
		'{8'd60,  ETYPE_IPV4, PROTO_UDP,  16'd0,     16'd0,     1'b1, CLASS_IPV4_UDP,   APP_NONE}
	};

	initial begin
		int rand_start;
		int rand_frames;
		int len;
		int hend;
		int pick;
		logic [15:0] et;
		logic [7:0] pr;
		logic [15:0] sp;
		logic [15:0] dp;

		clear_capture();
		for (int i = 0; i < NUM_CNT; i++) cnt_q[i] = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_frame(int'(dir_rows[i].len), dir_rows[i].et, dir_rows[i].pr, dir_rows[i].sp,
			           dir_rows[i].dp, dir_rows[i].typed, dir_rows[i].cls, dir_rows[i].app);
		drain_pause();

		// Random part: mostly well-formed IPv4/IPv6/ARP headers with random
		// payload, some cut short; the rest is noise with random ethertype.
		rand_start = byte_cnt;
		rand_frames = 0;
		while (byte_cnt - rand_start < RAND_BYTES || rand_frames < RAND_FRAMES) begin
			if (rand_frames % 20 == 19) drain_pause();
			if ($urandom_range(0, 9) < 7) begin
				pick = $urandom_range(0, 5);
				et = (pick < 3) ? ETYPE_IPV4 : (pick < 5) ? ETYPE_IPV6 : ETYPE_ARP;
				case ($urandom_range(0, 5))
					0, 1: pr = PROTO_TCP;
					2, 3: pr = PROTO_UDP;
					4: pr = PROTO_ICMP;
					default: pr = 8'($urandom);
				endcase
				sp = pick_port();
				dp = pick_port();
				hend = (et == ETYPE_IPV6) ? 58 : 38;
				pick = $urandom_range(0, 9);
				if (pick < 6) len = hend + $urandom_range(0, 20);
				else if (pick == 6) len = $urandom_range(64, 100);
				else len = $urandom_range(1, hend);
			end else begin
				et = 16'($urandom);
				pr = 8'($urandom);
				sp = 16'($urandom);
				dp = 16'($urandom);
				len = $urandom_range(1, 40);
			end
			send_frame(len, et, pr, sp, dp, 1'b0, CLASS_OTHER, APP_NONE);
			rand_frames++;
		end

		item_valid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("run: %0d frames, %0d bytes, %0d results checked under random stalls",
		         frame_cnt, byte_cnt, checked);
		$display("mix: arp %0d ipv4 %0d ipv6 %0d tcp %0d udp %0d http %0d smtp %0d dns %0d ftp %0d",
		         cnt_q[CNT_ARP], cnt_q[CNT_IPV4], cnt_q[CNT_IPV6], cnt_q[CNT_TCP],
		         cnt_q[CNT_UDP], cnt_q[CNT_HTTP], cnt_q[CNT_SMTP], cnt_q[CNT_DNS],
		         cnt_q[CNT_FTP]);
		if (err_cnt == 0)
			$display("[packet_type_classifier_counters_unit] OK");
		else
			$display("[packet_type_classifier_counters_unit] ERROR");
		$finish;
	end

endmodule
